// ===== rtl/ibe_pkg.sv =====
// ----------------------------------------------------------------------------
// ibe_pkg - i2c master byte engine package
// Word types, operation codes, sequencer states and slot-plan constants.
// ----------------------------------------------------------------------------
`default_nettype none

package ibe_pkg;

  localparam int unsigned SlotW  = 6;
  localparam int unsigned ByteW  = 8;
  localparam int unsigned OpW    = 3;

  // operation codes carried in the command word
  typedef enum logic [OpW-1:0] {
    OP_START = 3'd0,
    OP_STOP  = 3'd1,
    OP_WRITE = 3'd2,
    OP_READ  = 3'd3,
    OP_ACK   = 3'd4
  } op_e;

  // sequencer state, one-hot
  typedef enum logic [5:0] {
    ST_IDLE  = 6'b000001,
    ST_START = 6'b000010,
    ST_STOP  = 6'b000100,
    ST_WRITE = 6'b001000,
    ST_READ  = 6'b010000,
    ST_ACK   = 6'b100000
  } state_e;

  // final slot of each command
  localparam logic [SlotW-1:0] StartLast = 6'd3;
  localparam logic [SlotW-1:0] StopLast  = 6'd2;
  localparam logic [SlotW-1:0] WriteLast = 6'd19;
  localparam logic [SlotW-1:0] ReadLast  = 6'd32;
  localparam logic [SlotW-1:0] AckLast   = 6'd2;

  // write plan landmarks
  localparam logic [SlotW-1:0] WrDataEnd = 6'd16;
  localparam logic [SlotW-1:0] WrSdaRel  = 6'd17;
  localparam logic [SlotW-1:0] WrAckSmp  = 6'd18;

  // read plan landmarks
  localparam logic [SlotW-1:0] RdDataEnd = 6'd32;
  localparam logic [1:0]       RdPhLow   = 2'd1;
  localparam logic [1:0]       RdPhHigh  = 2'd2;

  typedef struct packed {
    logic             cmd_valid;
    logic [OpW-1:0]   operation;
    logic [ByteW-1:0] tx_byte;
    logic             ack_bit;
    logic             sda_in;
  } cmd_t;

  typedef struct packed {
    logic             scl_out;
    logic             sda_out;
    logic             busy_res;
    logic             done_res;
    logic [ByteW-1:0] rx_byte;
    logic             ack_received;
  } res_t;

endpackage

`default_nettype wire

// ===== rtl/ibe_if.sv =====
// ----------------------------------------------------------------------------
// ibe_if - valid/ready channels of the i2c master byte engine
// One channel for slot words going in, one for result words coming out.
// ----------------------------------------------------------------------------
`default_nettype none

interface ibe_cmd_if;
  import ibe_pkg::*;

  logic valid;
  logic ready;
  cmd_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

interface ibe_res_if;
  import ibe_pkg::*;

  logic valid;
  logic ready;
  res_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

// ===== rtl/i2c_master_byte_engine_top.sv =====
// ----------------------------------------------------------------------------
// i2c_master_byte_engine_top - slot-driven i2c master byte controller
// Each slot word advances the bus sequencer by one timing slot and yields
// one result word with the SCL/SDA levels and status for that slot.
//
// Usage:
//   cmd_i : slot words (command offer, operation, tx byte, ack bit, sampled
//           SDA). A command is taken only when the sequencer is idle.
//   res_o : one result word per slot word, in order.
//   A slot word's result sits in the output register on the cycle after
//   it is accepted. Unless the output stalls, one slot word is taken per
//   cycle; the sequencer state and output register update in one pass.
//   Start runs 4 slots, stop 3, byte write 20, byte read 33, ack bit 3.
//   When the receiver stalls, the output register holds its word and cmd_i
//   ready drops until it is taken; ready is high whenever the output
//   register is empty or being emptied in the same cycle.
//   After reset the sequencer is idle, both lines are released high and
//   the received byte and ack flag read zero.
// ----------------------------------------------------------------------------
`default_nettype none

module i2c_master_byte_engine_top (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  ibe_cmd_if.sink   cmd_i,
  ibe_res_if.source res_o
);
  import ibe_pkg::*;

  state_e           state_q, state_d, cur_st;
  logic [SlotW-1:0] slot_q, slot_d, s;
  logic [ByteW-1:0] shift_q, shift_d, shift_cur, wr_shifted;
  logic             ack_q, ack_d;
  logic [ByteW-1:0] rx_q, rx_d;
  logic             scl_q, scl_d;
  logic             sda_q, sda_d;
  logic [SlotW-1:0] last;
  logic             take, busy, done;
  logic             in_acc, out_valid_q;
  res_t             res_q, res_d;

  // handshake: accept while output register is empty or draining
  assign cmd_i.ready = !out_valid_q || res_o.ready;
  assign in_acc      = cmd_i.valid && cmd_i.ready;
  assign res_o.valid = out_valid_q;
  assign res_o.data  = res_q;

  // command pickup
  always_comb begin
    take   = 1'b0;
    cur_st = state_q;
    if (state_q == ST_IDLE && cmd_i.data.cmd_valid) begin
      take = 1'b1;
      unique case (cmd_i.data.operation)
        OP_START: cur_st = ST_START;
        OP_STOP:  cur_st = ST_STOP;
        OP_WRITE: cur_st = ST_WRITE;
        OP_READ:  cur_st = ST_READ;
        OP_ACK:   cur_st = ST_ACK;
        default: begin
          take   = 1'b0;
          cur_st = ST_IDLE;
        end
      endcase
    end
  end

  assign s = take ? '0 : slot_q;

  always_comb begin
    shift_cur = shift_q;
    if (take && cur_st == ST_WRITE) begin
      shift_cur = cmd_i.data.tx_byte;
    end else if (take && cur_st == ST_READ) begin
      shift_cur = '0;
    end
  end

  assign wr_shifted = shift_cur << s[3:1];

  // slot plan
  always_comb begin
    scl_d   = scl_q;
    sda_d   = sda_q;
    shift_d = shift_cur;
    ack_d   = ack_q;
    rx_d    = rx_q;
    last    = '0;
    busy    = 1'b1;
    unique case (cur_st)
      ST_IDLE: begin
        busy = 1'b0;
      end
      ST_START: begin
        last = StartLast;
        if (s == 6'd0) begin
          sda_d = 1'b1;
        end else if (s == 6'd1) begin
          scl_d = 1'b1;
        end else if (s == 6'd2) begin
          sda_d = 1'b0;
        end else begin
          scl_d = 1'b0;
        end
      end
      ST_STOP: begin
        last = StopLast;
        if (s == 6'd0) begin
          sda_d = 1'b0;
        end else if (s == 6'd1) begin
          scl_d = 1'b1;
        end else begin
          sda_d = 1'b1;
        end
      end
      ST_WRITE: begin
        last = WriteLast;
        if (s < WrDataEnd) begin
          if (!s[0]) begin
            if (s != 6'd0) scl_d = 1'b0;
            sda_d = wr_shifted[ByteW-1];
          end else begin
            scl_d = 1'b1;
          end
        end else if (s == WrDataEnd) begin
          scl_d = 1'b0;
        end else if (s == WrSdaRel) begin
          sda_d = 1'b1;
        end else if (s == WrAckSmp) begin
          scl_d = 1'b1;
          ack_d = !cmd_i.data.sda_in;
        end else begin
          scl_d = 1'b0;
        end
      end
      ST_READ: begin
        last = ReadLast;
        if (s == 6'd0) sda_d = 1'b1;
        if (s < RdDataEnd) begin
          if (s[1:0] == RdPhLow) begin
            scl_d = 1'b0;
          end else if (s[1:0] == RdPhHigh) begin
            scl_d   = 1'b1;
            shift_d = {shift_cur[ByteW-2:0], cmd_i.data.sda_in};
          end
        end else begin
          scl_d = 1'b0;
          rx_d  = shift_cur;
        end
      end
      ST_ACK: begin
        last = AckLast;
        if (s == 6'd0) begin
          sda_d = cmd_i.data.ack_bit;
        end else if (s == 6'd1) begin
          scl_d = 1'b1;
        end else begin
          scl_d = 1'b0;
        end
      end
      default: begin
        busy = 1'b0;
      end
    endcase
  end

  // slot counter and completion
  always_comb begin
    done    = 1'b0;
    state_d = cur_st;
    slot_d  = slot_q;
    if (busy) begin
      if (s >= last) begin
        done    = 1'b1;
        state_d = ST_IDLE;
        slot_d  = '0;
      end else begin
        slot_d = s + 6'd1;
      end
    end
  end

  // result word
  always_comb begin
    res_d.scl_out      = scl_d;
    res_d.sda_out      = sda_d;
    res_d.busy_res     = busy;
    res_d.done_res     = done;
    res_d.rx_byte      = rx_d;
    res_d.ack_received = ack_d;
  end

  // sequencer state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      slot_q  <= '0;
      shift_q <= '0;
      ack_q   <= 1'b0;
      rx_q    <= '0;
      scl_q   <= 1'b1;
      sda_q   <= 1'b1;
    end else if (in_acc) begin
      state_q <= state_d;
      slot_q  <= slot_d;
      shift_q <= shift_d;
      ack_q   <= ack_d;
      rx_q    <= rx_d;
      scl_q   <= scl_d;
      sda_q   <= sda_d;
    end
  end

  // output valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (in_acc) begin
      out_valid_q <= 1'b1;
    end else if (res_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  // output payload
  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      res_q <= res_d;
    end
  end

endmodule

`default_nettype wire

// ===== verif/tb_i2c_master_byte_engine_top.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_i2c_master_byte_engine_top - slot-level test of the i2c byte engine
// Drives slot words into the engine and predicts the SCL/SDA levels and
// status of every slot. Each result word is checked field by field. The
// run covers start, stop, byte write with ack and nack, byte read, the
// master ack bit, offers while busy, unknown operations, idle slots, long
// output stalls, and random command traffic with random idling.
// ----------------------------------------------------------------------------

module tb_i2c_master_byte_engine_top;
  import ibe_pkg::*;

  // slot plan of each command, as the bus timing requires
  localparam int unsigned StartFinal  = 3;
  localparam int unsigned StopFinal   = 2;
  localparam int unsigned WriteFinal  = 19;
  localparam int unsigned ReadFinal   = 32;
  localparam int unsigned AckFinal    = 2;
  localparam int unsigned WrDataSlots = 16;
  localparam int unsigned WrRelease   = 17;
  localparam int unsigned WrSample    = 18;
  localparam int unsigned RdDataSlots = 32;
  localparam int unsigned RdPhLo      = 1;
  localparam int unsigned RdPhHi      = 2;
  localparam int unsigned OpCount     = 5;
  localparam logic [OpW-1:0] OpTop    = '1;

  localparam int unsigned ResetCycles = 7;
  localparam int unsigned HoldCycles  = 48;
  localparam int unsigned DrainCycles = 8;
  localparam int unsigned CycleLimit  = 200000;
  localparam int unsigned MaxReports  = 40;

  logic clk_i;
  logic rst_ni;

  ibe_cmd_if cmd_if ();
  ibe_res_if res_if ();

  i2c_master_byte_engine_top u_dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cmd_i  (cmd_if),
    .res_o  (res_if)
  );

  // bus sequencer mirror, reset values
  bit          seq_busy = 1'b0;
  op_e         seq_op   = OP_START;
  int unsigned seq_slot = 0;
  logic [7:0]  seq_shift = '0;
  logic [7:0]  rx_last  = '0;
  logic        ack_seen = 1'b0;
  logic        line_scl = 1'b1;
  logic        line_sda = 1'b1;

  res_t        slot_expect_q[$];
  int unsigned fail_count = 0;
  int unsigned slots_sent = 0;
  int unsigned words_checked = 0;
  int unsigned cmds_taken [OpCount];
  int unsigned cycle_count = 0;
  bit          src_gaps  = 1'b1;
  bit          sink_gaps = 1'b1;
  bit          hold_req  = 1'b0;

  // clock
  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // run limit
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CycleLimit) begin
      $display("timeout after %0d cycles, %0d words outstanding", cycle_count,
               slot_expect_q.size());
      $display("*** FAILED ***");
      $finish;
    end
  end

  // advance the sequencer mirror by one slot and form that slot's word
  task automatic advance_bus_slot(input cmd_t w, output res_t r);
    int unsigned s;
    int unsigned final_slot;
    logic        scl;
    logic        sda;
    scl = line_scl;
    sda = line_sda;
    final_slot = 0;
    r = '0;
    if (!seq_busy && w.cmd_valid && w.operation <= OP_ACK) begin
      seq_busy = 1'b1;
      seq_op   = op_e'(w.operation);
      seq_slot = 0;
      cmds_taken[w.operation]++;
      if (seq_op == OP_WRITE) seq_shift = w.tx_byte;
      else if (seq_op == OP_READ) seq_shift = '0;
    end
    if (seq_busy) begin
      s = seq_slot;
      r.busy_res = 1'b1;
      case (seq_op)
        OP_START: begin
          final_slot = StartFinal;
          if (s == 0) sda = 1'b1;
          else if (s == 1) scl = 1'b1;
          else if (s == 2) sda = 1'b0;
          else scl = 1'b0;
        end
        OP_STOP: begin
          final_slot = StopFinal;
          if (s == 0) sda = 1'b0;
          else if (s == 1) scl = 1'b1;
          else sda = 1'b1;
        end
        OP_WRITE: begin
          final_slot = WriteFinal;
          if (s < WrDataSlots) begin
            // even slots put a data bit on sda, odd slots raise scl
            if (s % 2 == 0) begin
              if (s != 0) scl = 1'b0;
              sda = seq_shift[7 - s / 2];
            end else begin
              scl = 1'b1;
            end
          end else if (s == WrDataSlots) begin
            scl = 1'b0;
          end else if (s == WrRelease) begin
            sda = 1'b1;
          end else if (s == WrSample) begin
            scl = 1'b1;
            ack_seen = ~w.sda_in;
          end else begin
            scl = 1'b0;
          end
        end
        OP_READ: begin
          final_slot = ReadFinal;
          if (s == 0) sda = 1'b1;
          if (s < RdDataSlots) begin
            if (s % 4 == RdPhLo) begin
              scl = 1'b0;
            end else if (s % 4 == RdPhHi) begin
              scl = 1'b1;
              seq_shift = {seq_shift[6:0], w.sda_in};
            end
          end else begin
            scl = 1'b0;
            rx_last = seq_shift;
          end
        end
        default: begin
          final_slot = AckFinal;
          if (s == 0) sda = w.ack_bit;
          else if (s == 1) scl = 1'b1;
          else scl = 1'b0;
        end
      endcase
      if (s >= final_slot) begin
        r.done_res = 1'b1;
        seq_busy = 1'b0;
        seq_slot = 0;
      end else begin
        seq_slot = s + 1;
      end
    end
    line_scl = scl;
    line_sda = sda;
    r.scl_out      = scl;
    r.sda_out      = sda;
    r.rx_byte      = rx_last;
    r.ack_received = ack_seen;
  endtask

  // offer one slot word, wait for it to be taken, record its prediction
  task automatic send_slot(input cmd_t w);
    res_t want;
    if (src_gaps && $urandom_range(0, 4) == 0) begin
      cmd_if.valid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk_i);
    end
    cmd_if.valid <= 1'b1;
    cmd_if.data  <= w;
    @(posedge clk_i);
    while (!cmd_if.ready) @(posedge clk_i);
    advance_bus_slot(w, want);
    slot_expect_q.push_back(want);
    slots_sent++;
  endtask

  // level the slave puts on sda in a given slot of a command
  function automatic logic slave_sda(input logic [OpW-1:0] code, input int unsigned s,
                                     input logic [7:0] slave_byte, input logic slave_nack);
    if (code == OP_READ && s < RdDataSlots && s % 4 == RdPhHi) return slave_byte[7 - s / 4];
    if (code == OP_WRITE && s == WrSample) return slave_nack;
    return 1'($urandom_range(0, 1));
  endfunction

  // issue one command and feed slots until it completes; offers during the
  // command come at the given percentage with random content
  task automatic run_command(input logic [OpW-1:0] code, input logic [7:0] tx,
                             input logic ab, input logic [7:0] slave_byte,
                             input logic slave_nack, input int unsigned offer_pct);
    cmd_t w;
    w.cmd_valid = 1'b1;
    w.operation = code;
    w.tx_byte   = tx;
    w.ack_bit   = ab;
    w.sda_in    = 1'($urandom_range(0, 1));
    send_slot(w);
    while (seq_busy) begin
      w.cmd_valid = ($urandom_range(0, 99) < offer_pct);
      w.operation = OpW'($urandom);
      w.tx_byte   = 8'($urandom);
      w.ack_bit   = 1'($urandom);
      w.sda_in    = slave_sda(code, seq_slot, slave_byte, slave_nack);
      send_slot(w);
    end
  endtask

  // idle slots with random content
  task automatic send_quiet(input int unsigned n);
    cmd_t w;
    repeat (n) begin
      w = cmd_t'($urandom);
      w.cmd_valid = 1'b0;
      send_slot(w);
    end
  endtask

  // let every expected word arrive, always waiting on the clock before the first check
  task automatic wait_drained();
    cmd_if.valid <= 1'b0;
    do @(posedge clk_i); while (slot_expect_q.size() != 0);
  endtask

  // receiver: random stalls, or one long hold on request
  initial begin : sink_ready
    res_if.ready <= 1'b0;
    @(posedge rst_ni);
    forever begin
      @(posedge clk_i);
      if (hold_req) begin
        res_if.ready <= 1'b0;
        repeat (HoldCycles) @(posedge clk_i);
        hold_req = 1'b0;
        res_if.ready <= 1'b1;
      end else if (sink_gaps && $urandom_range(0, 5) == 0) begin
        res_if.ready <= 1'b0;
        repeat ($urandom_range(1, 4)) @(posedge clk_i);
        res_if.ready <= 1'b1;
      end else begin
        res_if.ready <= 1'b1;
      end
    end
  end

  function automatic void check_field(input string field, input logic [7:0] want,
                                      input logic [7:0] got);
    if (got !== want) begin
      fail_count++;
      if (fail_count <= MaxReports)
        $display("%0t: %s mismatch, expected %0h, actual %0h", $time, field, want, got);
    end
  endfunction

  // compare each taken result word with the oldest prediction
  always @(posedge clk_i) begin : check_words
    res_t want;
    res_t got;
    if (rst_ni && res_if.valid && res_if.ready) begin
      got = res_if.data;
      if (slot_expect_q.size() == 0) begin
        fail_count++;
        if (fail_count <= MaxReports)
          $display("%0t: unexpected word, expected none, actual %h", $time, got);
      end else begin
        want = slot_expect_q.pop_front();
        words_checked++;
        check_field("scl_out", 8'(want.scl_out), 8'(got.scl_out));
        check_field("sda_out", 8'(want.sda_out), 8'(got.sda_out));
        check_field("busy_res", 8'(want.busy_res), 8'(got.busy_res));
        check_field("done_res", 8'(want.done_res), 8'(got.done_res));
        check_field("rx_byte", want.rx_byte, got.rx_byte);
        check_field("ack_received", 8'(want.ack_received), 8'(got.ack_received));
      end
    end
  end

  // idle slots hold released lines and report zero status
  task automatic test_idle_slots();
    send_quiet(3);
  endtask

  // offers of unused operation codes while idle are dropped
  task automatic test_unknown_ops();
    for (int unsigned c = int'(OP_ACK) + 1; c <= int'(OpTop); c++)
      run_command(OpW'(c), 8'hff, 1'b1, 8'h00, 1'b0, 0);
  endtask

  task automatic test_start_stop();
    run_command(OP_START, 8'h00, 1'b0, 8'h00, 1'b0, 0);
    run_command(OP_STOP, 8'hff, 1'b1, 8'h00, 1'b0, 0);
  endtask

  // write extremes, with nack and ack in the ack slot
  task automatic test_write_byte();
    run_command(OP_WRITE, 8'h00, 1'b0, 8'h00, 1'b1, 0);
    run_command(OP_WRITE, 8'hff, 1'b1, 8'h00, 1'b0, 0);
    run_command(OP_WRITE, 8'ha5, 1'b0, 8'h00, 1'b1, 0);
  endtask

  task automatic test_read_byte();
    run_command(OP_READ, 8'h00, 1'b0, 8'hff, 1'b0, 0);
    run_command(OP_READ, 8'hff, 1'b1, 8'h00, 1'b0, 0);
    run_command(OP_READ, 8'h00, 1'b0, 8'h5a, 1'b0, 0);
  endtask

  task automatic test_master_ack();
    run_command(OP_ACK, 8'h00, 1'b0, 8'h00, 1'b0, 0);
    run_command(OP_ACK, 8'hff, 1'b1, 8'h00, 1'b0, 0);
  endtask

  // every slot of a running command carries a new offer
  task automatic test_busy_offers();
    run_command(OP_READ, 8'h3c, 1'b1, 8'hc3, 1'b0, 100);
    run_command(OP_WRITE, 8'h81, 1'b0, 8'h00, 1'b0, 100);
  endtask

  // long receiver hold while the sender keeps offering
  task automatic test_output_stall();
    hold_req = 1'b1;
    run_command(OP_WRITE, 8'($urandom), 1'b0, 8'h00, 1'($urandom), 50);
    run_command(OP_READ, 8'h00, 1'b0, 8'($urandom), 1'b0, 0);
    wait (!hold_req);
  endtask

  // sender stops until every word is back, then resumes
  task automatic test_sender_pause();
    run_command(OP_START, 8'h00, 1'b0, 8'h00, 1'b0, 0);
    wait_drained();
    run_command(OP_WRITE, 8'($urandom), 1'b1, 8'h00, 1'b0, 0);
    wait_drained();
    send_quiet(2);
  endtask

  // mostly complete commands with random content, some quiet slots and
  // unused operation codes
  task automatic test_random_traffic(input int unsigned n_slots, input bit with_gaps);
    int unsigned stop_at;
    int unsigned pick;
    logic [OpW-1:0] code;
    src_gaps  = with_gaps;
    sink_gaps = with_gaps;
    stop_at = slots_sent + n_slots;
    while (slots_sent < stop_at) begin
      pick = $urandom_range(0, 99);
      if (pick < 85) begin
        code = OpW'($urandom_range(int'(OP_START), int'(OP_ACK)));
        run_command(code, 8'($urandom), 1'($urandom), 8'($urandom), 1'($urandom),
                    ($urandom_range(0, 3) == 0) ? 50 : 0);
      end else if (pick < 93) begin
        send_quiet($urandom_range(1, 3));
      end else begin
        code = OpW'($urandom_range(int'(OP_ACK) + 1, int'(OpTop)));
        run_command(code, 8'($urandom), 1'($urandom), 8'h00, 1'b0, 0);
      end
    end
  endtask

  initial begin : main_seq
    rst_ni <= 1'b0;
    cmd_if.valid <= 1'b0;
    cmd_if.data  <= '0;
    repeat (ResetCycles) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_idle_slots();
    test_unknown_ops();
    test_start_stop();
    test_write_byte();
    test_read_byte();
    test_master_ack();
    test_busy_offers();
    test_output_stall();
    test_sender_pause();
    test_random_traffic(1000, 1'b1);
    test_random_traffic(300, 1'b0);

    wait_drained();
    repeat (DrainCycles) @(posedge clk_i);
    $display("%0d slot words sent, %0d checked; commands start %0d stop %0d write %0d",
             slots_sent, words_checked, cmds_taken[OP_START], cmds_taken[OP_STOP],
             cmds_taken[OP_WRITE]);
    $display("read %0d ack %0d; %0d field mismatches", cmds_taken[OP_READ],
             cmds_taken[OP_ACK], fail_count);
    if (fail_count == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

// ===== files.f =====
rtl/ibe_pkg.sv
rtl/ibe_if.sv
rtl/i2c_master_byte_engine_top.sv
verif/tb_i2c_master_byte_engine_top.sv
